>>> src/dtq_pkg.sv
// Package for the delta timer queue: default sizes, transaction codes and the
// flag bundle of the shared compare unit. No dependencies.
`default_nettype none
package dtq_pkg;

	localparam int NUM_TASKS_DEF  = 16;
	localparam int DELAY_BITS_DEF = 32;

	// Field widths fixed by the interface.
	localparam int ACTION_W  = 2;
	localparam int TASK_W    = 4;
	localparam int DELAY_W   = 32;
	localparam int KIND_W    = 2;
	localparam int MISSED_W  = 32;
	localparam int AGE_W     = MISSED_W + 1;
	localparam int ID_EXT_W  = 7;

	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MISSED = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_WAKE   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REFUSED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

	typedef struct packed {
		logic eq;       // remaining count equals the reference count
		logic lt;       // earlier than the reference (count, then rank)
		logic rank_gt;  // rank above the reference rank
		logic due;      // remaining count within the current aging
	} cmp_flags_t;

endpackage
`default_nettype wire

>>> src/delta_timer_queue.sv
// Delta timer queue: accepted inserts and wakes and every tick are handled by
// scanning the task slots through one memory read port and one shared compare
// unit, one slot a cycle. A missed tick only bumps a count. A tick runs one aging
// scan and, if any task is due, one selection scan and an emit step per expired
// task. Zero or all-ones insert delays and refused requests need no scan.
// Reset clears all waiting bits and the missed count at once; no clearing pass.
`default_nettype none
module delta_timer_queue import dtq_pkg::*; #(
	parameter int NUM_TASKS  = NUM_TASKS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [TASK_W-1:0]   task_id,
	input  wire logic [DELAY_W-1:0]  delay,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [KIND_W-1:0]        kind,
	output logic [TASK_W-1:0]        expired_task,
	output logic                     last
);

	localparam int IW     = $clog2(NUM_TASKS);
	localparam int RANK_W = IW;
	localparam int CW     = $clog2(NUM_TASKS + 1);
	localparam int WORD_W = RANK_W + DELAY_BITS;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RESP     = 4'd1;
	localparam logic [3:0] S_INS_SCAN = 4'd2;
	localparam logic [3:0] S_WK_RD    = 4'd3;
	localparam logic [3:0] S_WK_CAP   = 4'd4;
	localparam logic [3:0] S_WK_SCAN  = 4'd5;
	localparam logic [3:0] S_AGE_SCAN = 4'd6;
	localparam logic [3:0] S_SEL_SCAN = 4'd7;
	localparam logic [3:0] S_EMIT     = 4'd8;

	logic [3:0]            state_q;
	logic [NUM_TASKS-1:0]  waiting_q;
	logic [NUM_TASKS-1:0]  due_q;
	logic [CW-1:0]         due_cnt_q;
	logic [MISSED_W-1:0]   missed_q;
	logic [AGE_W-1:0]      age_q;
	logic [CW-1:0]         cnt_q;
	logic                  proc_vld_s1;
	logic [IW-1:0]         proc_idx_s1;
	logic [IW-1:0]         id_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic [RANK_W-1:0]     rank_cnt_q;
	logic [DELAY_BITS-1:0] tgt_rem_q;
	logic [RANK_W-1:0]     tgt_rank_q;
	logic                  best_vld_q;
	logic [IW-1:0]         best_idx_q;
	logic [DELAY_BITS-1:0] best_rem_q;
	logic [RANK_W-1:0]     best_rank_q;
	logic [KIND_W-1:0]     resp_kind_q;
	logic [TASK_W-1:0]     resp_task_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [TASK_W-1:0]     expired_task_q;
	logic                  last_q;

	logic [WORD_W-1:0]     mem [NUM_TASKS];
	logic [WORD_W-1:0]     rd_data_q;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [WORD_W-1:0]     wr_data;

	logic [DELAY_BITS-1:0] rem_rd;
	logic [RANK_W-1:0]     rank_rd;
	logic [DELAY_BITS-1:0] ref_rem;
	logic [RANK_W-1:0]     ref_rank;
	logic [DELAY_BITS-1:0] aged_rem;
	cmp_flags_t            flags;

	logic                  in_acc;
	logic                  out_free;
	logic                  out_load;
	logic                  scanning;
	logic                  issue;
	logic                  scan_done;
	logic                  proc_wait;
	logic                  id_ok;
	logic [IW-1:0]         in_slot;
	logic [DELAY_BITS-1:0] in_delay;
	logic [ID_EXT_W-1:0]   id_ext;
	logic [ID_EXT_W-1:0]   best_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = ((state_q == S_RESP) || (state_q == S_EMIT)) && out_free;
	assign out_valid = out_valid_q;
	assign kind         = kind_q;
	assign expired_task = expired_task_q;
	assign last         = last_q;

	assign scanning  = (state_q == S_INS_SCAN) || (state_q == S_WK_SCAN) ||
		(state_q == S_AGE_SCAN) || (state_q == S_SEL_SCAN);
	assign issue     = scanning && (cnt_q < CW'(NUM_TASKS));
	assign scan_done = scanning && (cnt_q == CW'(NUM_TASKS)) && !proc_vld_s1;
	assign proc_wait = proc_vld_s1 && waiting_q[proc_idx_s1];

	assign id_ext   = ID_EXT_W'(task_id);
	assign id_ok    = id_ext < ID_EXT_W'(NUM_TASKS);
	assign in_slot  = id_ext[IW-1:0];
	assign in_delay = delay[DELAY_BITS-1:0];
	assign best_ext = ID_EXT_W'(best_idx_q);

	assign rem_rd  = rd_data_q[DELAY_BITS-1:0];
	assign rank_rd = rd_data_q[WORD_W-1:DELAY_BITS];

	always_comb begin
		case (state_q)
			S_INS_SCAN: begin
				ref_rem  = delay_q;
				ref_rank = '0;
			end
			S_WK_SCAN: begin
				ref_rem  = tgt_rem_q;
				ref_rank = tgt_rank_q;
			end
			default: begin
				ref_rem  = best_rem_q;
				ref_rank = best_rank_q;
			end
		endcase
	end

	dtq_cmp_unit #(
		.DELAY_BITS(DELAY_BITS),
		.RANK_W    (RANK_W)
	) u_cmp (
		.rem      (rem_rd),
		.rank     (rank_rd),
		.ref_rem  (ref_rem),
		.ref_rank (ref_rank),
		.age      (age_q),
		.flags    (flags),
		.aged_rem (aged_rem)
	);

	always_comb begin
		rd_en   = issue || (state_q == S_WK_RD);
		rd_addr = (state_q == S_WK_RD) ? id_q : cnt_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = proc_idx_s1;
		wr_data = {rank_rd, aged_rem};
		case (state_q)
			S_AGE_SCAN: begin
				wr_en = proc_wait && !flags.due;
			end
			S_WK_SCAN: begin
				wr_en   = proc_wait && (proc_idx_s1 != id_q) && flags.eq && flags.rank_gt;
				wr_data = {rank_rd - RANK_W'(1), rem_rd};
			end
			S_INS_SCAN: begin
				wr_en   = scan_done;
				wr_addr = id_q;
				wr_data = {rank_cnt_q, delay_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Slot memory: entries of idle slots are never looked at, so it needs no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			waiting_q      <= '0;
			due_q          <= '0;
			due_cnt_q      <= '0;
			missed_q       <= '0;
			age_q          <= '0;
			cnt_q          <= '0;
			proc_vld_s1    <= 1'b0;
			proc_idx_s1    <= '0;
			id_q           <= '0;
			delay_q        <= '0;
			rank_cnt_q     <= '0;
			tgt_rem_q      <= '0;
			tgt_rank_q     <= '0;
			best_vld_q     <= 1'b0;
			best_idx_q     <= '0;
			best_rem_q     <= '0;
			best_rank_q    <= '0;
			resp_kind_q    <= KIND_ACCEPTED;
			resp_task_q    <= '0;
			out_valid_q    <= 1'b0;
			kind_q         <= KIND_ACCEPTED;
			expired_task_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Common scan pipeline: address issued now, data processed next cycle.
			if (scanning) begin
				if (issue) begin
					cnt_q       <= cnt_q + CW'(1);
					proc_vld_s1 <= 1'b1;
					proc_idx_s1 <= cnt_q[IW-1:0];
				end else begin
					proc_vld_s1 <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						id_q        <= in_slot;
						delay_q     <= in_delay;
						resp_task_q <= (action == ACT_MISSED) ? '0 : task_id;
						cnt_q       <= '0;
						proc_vld_s1 <= 1'b0;
						case (action)
							ACT_TICK: begin
								age_q     <= AGE_W'(missed_q) + AGE_W'(1);
								missed_q  <= '0;
								due_q     <= '0;
								due_cnt_q <= '0;
								state_q   <= S_AGE_SCAN;
							end
							ACT_MISSED: begin
								if (missed_q != '1) begin
									missed_q <= missed_q + MISSED_W'(1);
								end
								resp_kind_q <= KIND_ACCEPTED;
								state_q     <= S_RESP;
							end
							ACT_INSERT: begin
								rank_cnt_q <= '0;
								if (!id_ok || waiting_q[in_slot]) begin
									resp_kind_q <= KIND_REFUSED;
									state_q     <= S_RESP;
								end else if ((in_delay == '0) || (in_delay == '1)) begin
									resp_kind_q <= KIND_ACCEPTED;
									state_q     <= S_RESP;
								end else begin
									resp_kind_q <= KIND_ACCEPTED;
									state_q     <= S_INS_SCAN;
								end
							end
							default: begin
								if (!id_ok || !waiting_q[in_slot]) begin
									resp_kind_q <= KIND_REFUSED;
									state_q     <= S_RESP;
								end else begin
									resp_kind_q <= KIND_ACCEPTED;
									state_q     <= S_WK_RD;
								end
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						kind_q         <= resp_kind_q;
						expired_task_q <= resp_task_q;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_INS_SCAN: begin
					if (proc_wait && flags.eq) begin
						rank_cnt_q <= rank_cnt_q + RANK_W'(1);
					end
					if (scan_done) begin
						waiting_q[id_q] <= 1'b1;
						state_q         <= S_RESP;
					end
				end
				S_WK_RD: begin
					state_q <= S_WK_CAP;
				end
				S_WK_CAP: begin
					tgt_rem_q  <= rem_rd;
					tgt_rank_q <= rank_rd;
					state_q    <= S_WK_SCAN;
				end
				S_WK_SCAN: begin
					if (scan_done) begin
						waiting_q[id_q] <= 1'b0;
						state_q         <= S_RESP;
					end
				end
				S_AGE_SCAN: begin
					if (proc_wait && flags.due) begin
						due_q[proc_idx_s1] <= 1'b1;
						due_cnt_q          <= due_cnt_q + CW'(1);
					end
					if (scan_done) begin
						cnt_q      <= '0;
						best_vld_q <= 1'b0;
						if (due_cnt_q == '0) begin
							resp_kind_q <= KIND_NONE;
							resp_task_q <= '0;
							state_q     <= S_RESP;
						end else begin
							state_q <= S_SEL_SCAN;
						end
					end
				end
				S_SEL_SCAN: begin
					if (proc_vld_s1 && due_q[proc_idx_s1] && (!best_vld_q || flags.lt)) begin
						best_vld_q  <= 1'b1;
						best_idx_q  <= proc_idx_s1;
						best_rem_q  <= rem_rd;
						best_rank_q <= rank_rd;
					end
					if (scan_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						kind_q                <= KIND_EXPIRED;
						expired_task_q        <= best_ext[TASK_W-1:0];
						last_q                <= (due_cnt_q == CW'(1));
						waiting_q[best_idx_q] <= 1'b0;
						due_q[best_idx_q]     <= 1'b0;
						due_cnt_q             <= due_cnt_q - CW'(1);
						cnt_q                 <= '0;
						best_vld_q            <= 1'b0;
						if (due_cnt_q == CW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SEL_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("block took a transaction and stayed ready");

	a_due_count: assert property (@(posedge clk) disable iff (!arst_n)
		due_cnt_q == CW'($countones(due_q)))
		else $error("due count disagrees with the due flags");

	a_due_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(due_q & ~waiting_q) == '0)
		else $error("a slot is due but not waiting");

	a_only_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q || (kind_q == KIND_EXPIRED)))
		else $error("a non-final result that is not an expiry");

	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (best_vld_q && due_q[best_idx_q]))
		else $error("expiry emitted without a selected due slot");

endmodule
`default_nettype wire

>>> src/dtq_cmp_unit.sv
// Shared compare and subtract unit used by every slot scan of the timer queue.
// Depends on dtq_pkg.
`default_nettype none
module dtq_cmp_unit import dtq_pkg::*; #(
	parameter int DELAY_BITS = DELAY_BITS_DEF,
	parameter int RANK_W     = 4
) (
	input  wire logic [DELAY_BITS-1:0] rem,
	input  wire logic [RANK_W-1:0]     rank,
	input  wire logic [DELAY_BITS-1:0] ref_rem,
	input  wire logic [RANK_W-1:0]     ref_rank,
	input  wire logic [AGE_W-1:0]      age,
	output cmp_flags_t                 flags,
	output logic [DELAY_BITS-1:0]      aged_rem
);

	always_comb begin
		flags.eq      = (rem == ref_rem);
		flags.rank_gt = (rank > ref_rank);
		flags.lt      = (rem < ref_rem) || ((rem == ref_rem) && (rank < ref_rank));
		flags.due     = (AGE_W'(rem) <= age);
	end

	// Only used when the slot is not due, so the age fits in the count width.
	assign aged_rem = rem - age[DELAY_BITS-1:0];

endmodule
`default_nettype wire

>>> verif/tb_delta_timer_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for delta_timer_queue: a queue-fed driver, a monitor that
// predicts every reply from its own copy of the timer state, and a stall watchdog.
// Depends on dtq_pkg and delta_timer_queue.
module tb_delta_timer_queue;
	import dtq_pkg::*;

	localparam int N_TASKS = NUM_TASKS_DEF;
	localparam logic [DELAY_W-1:0] DLY_MASK = {DELAY_W{1'b1}} >> (DELAY_W - DELAY_BITS_DEF);
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [TASK_W-1:0]   id;
		logic [DELAY_W-1:0]  dly;
	} timer_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TASK_W-1:0] id;
		logic              fin;
	} timer_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = ACT_TICK;
	logic [TASK_W-1:0]   task_id = '0;
	logic [DELAY_W-1:0]  delay = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [TASK_W-1:0]   expired_task;
	logic                last;

	timer_req_t   pending_reqs[$];
	timer_reply_t pending_replies[$];
	logic         in_taken = 1'b0;
	int unsigned  send_idle_pct = 37;
	int unsigned  recv_idle_pct = 76;
	int unsigned  fault_count = 0;
	int unsigned  stall_cycles = 0;

	// Shadow copy of the timer state.
	logic [DELAY_W-1:0]  ticks_left[N_TASKS];
	bit                  armed[N_TASKS];
	int unsigned         tie_order[N_TASKS];
	logic [MISSED_W-1:0] missed_cnt;

	delta_timer_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.task_id      (task_id),
		.delay        (delay),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.expired_task (expired_task),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic timer_reply_t mk_reply(logic [KIND_W-1:0] k, logic [TASK_W-1:0] id,
			logic fin);
		timer_reply_t r;
		r.kind = k;
		r.id = id;
		r.fin = fin;
		return r;
	endfunction

	// Applies one transaction to the shadow state and queues the replies it causes.
	task automatic advance_timers(input timer_req_t rq);
		logic [AGE_W-1:0]   age;
		logic [DELAY_W-1:0] dly;
		bit                 due[N_TASKS];
		int                 fired[$];
		int                 best;
		int unsigned        peers;
		dly = rq.dly & DLY_MASK;
		case (rq.act)
			ACT_TICK: begin
				age = {1'b0, missed_cnt} + 1'b1;
				missed_cnt = '0;
				for (int i = 0; i < N_TASKS; i++)
					due[i] = armed[i] && ({1'b0, ticks_left[i]} <= age);
				// Soonest deadline first, ties broken by arrival order.
				do begin
					best = -1;
					for (int i = 0; i < N_TASKS; i++) begin
						if (due[i] && (best < 0 || ticks_left[i] < ticks_left[best] ||
								(ticks_left[i] == ticks_left[best] &&
								tie_order[i] < tie_order[best])))
							best = i;
					end
					if (best >= 0) begin
						due[best] = 1'b0;
						armed[best] = 1'b0;
						ticks_left[best] = '0;
						tie_order[best] = 0;
						fired.push_back(best);
					end
				end while (best >= 0);
				for (int i = 0; i < N_TASKS; i++) begin
					if (armed[i]) begin
						if ({1'b0, ticks_left[i]} <= age)
							ticks_left[i] = '0;
						else
							ticks_left[i] = ticks_left[i] - age[DELAY_W-1:0];
					end
				end
				if (fired.size() == 0)
					pending_replies.push_back(mk_reply(KIND_NONE, '0, 1'b1));
				else
					foreach (fired[k])
						pending_replies.push_back(mk_reply(KIND_EXPIRED, TASK_W'(fired[k]),
							k == fired.size() - 1));
			end
			ACT_MISSED: begin
				if (missed_cnt != '1)
					missed_cnt = missed_cnt + 1'b1;
				pending_replies.push_back(mk_reply(KIND_ACCEPTED, '0, 1'b1));
			end
			default: begin
				if (int'(rq.id) >= N_TASKS) begin
					pending_replies.push_back(mk_reply(KIND_REFUSED, rq.id, 1'b1));
				end else if (rq.act == ACT_INSERT) begin
					if (armed[rq.id]) begin
						pending_replies.push_back(mk_reply(KIND_REFUSED, rq.id, 1'b1));
					end else begin
						// A zero or all-ones delay is accepted but never queued.
						if (dly != '0 && dly != DLY_MASK) begin
							peers = 0;
							for (int i = 0; i < N_TASKS; i++)
								if (armed[i] && ticks_left[i] == dly)
									peers++;
							ticks_left[rq.id] = dly;
							tie_order[rq.id] = peers;
							armed[rq.id] = 1'b1;
						end
						pending_replies.push_back(mk_reply(KIND_ACCEPTED, rq.id, 1'b1));
					end
				end else if (!armed[rq.id]) begin
					pending_replies.push_back(mk_reply(KIND_REFUSED, rq.id, 1'b1));
				end else begin
					for (int i = 0; i < N_TASKS; i++)
						if (armed[i] && i != int'(rq.id) &&
								ticks_left[i] == ticks_left[rq.id] &&
								tie_order[i] > tie_order[rq.id])
							tie_order[i]--;
					armed[rq.id] = 1'b0;
					ticks_left[rq.id] = '0;
					tie_order[rq.id] = 0;
					pending_replies.push_back(mk_reply(KIND_ACCEPTED, rq.id, 1'b1));
				end
			end
		endcase
	endtask

	task automatic queue_req(input logic [ACTION_W-1:0] a, input logic [TASK_W-1:0] id,
			input logic [DELAY_W-1:0] d);
		timer_req_t rq;
		rq.act = a;
		rq.id = id;
		rq.dly = d;
		pending_reqs.push_back(rq);
	endtask

	// Mostly short delays so that deadlines collide and expire often; now and then
	// every slot is armed and then aged together.
	task automatic queue_random_reqs(input int count);
		int          made;
		int unsigned r;
		int unsigned s;
		logic [DELAY_W-1:0] d;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				for (int t = 0; t < N_TASKS; t++)
					queue_req(ACT_INSERT, TASK_W'(t), $urandom_range(1, 3));
				s = $urandom_range(0, 2);
				repeat (s) queue_req(ACT_MISSED, '0, $urandom);
				queue_req(ACT_TICK, TASK_W'($urandom_range(0, 15)), $urandom);
				made += N_TASKS + 1 + s;
			end else begin
				if (r < 48) begin
					s = $urandom_range(0, 99);
					if (s < 4)
						d = '0;
					else if (s < 7)
						d = '1;
					else if (s < 11)
						d = $urandom;
					else
						d = $urandom_range(1, 8);
					queue_req(ACT_INSERT, TASK_W'($urandom_range(0, 15)), d);
				end else if (r < 66) begin
					queue_req(ACT_WAKE, TASK_W'($urandom_range(0, 15)), $urandom);
				end else if (r < 80) begin
					queue_req(ACT_MISSED, TASK_W'($urandom_range(0, 15)), $urandom);
				end else begin
					queue_req(ACT_TICK, TASK_W'($urandom_range(0, 15)), $urandom);
				end
				made++;
			end
		end
	endtask

	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || in_valid || pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Driver: presents the next transaction once the previous one has been taken.
	always @(negedge clk) begin : drive_req
		timer_req_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				rq = pending_reqs.pop_front();
				in_valid <= 1'b1;
				action <= rq.act;
				task_id <= rq.id;
				delay <= rq.dly;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Monitor: checks each reply against the oldest prediction, then predicts
	// the replies of any transaction accepted at this edge.
	always @(posedge clk) begin : watch_ports
		timer_reply_t want;
		timer_req_t   seen;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected reply kind %0d task %0d last %0d",
						$time, kind, expired_task, last);
					fault_count++;
				end else begin
					want = pending_replies.pop_front();
					if (kind !== want.kind || expired_task !== want.id || last !== want.fin) begin
						$display("%0t: reply mismatch, expected kind %0d task %0d last %0d, got kind %0d task %0d last %0d",
							$time, want.kind, want.id, want.fin, kind, expired_task, last);
						fault_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				seen.act = action;
				seen.id = task_id;
				seen.dly = delay;
				advance_timers(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < N_TASKS; i++) begin
			ticks_left[i] = '0;
			armed[i] = 1'b0;
			tie_order[i] = 0;
		end
		missed_cnt = '0;

		// Directed opening: empty queue, unqueued delays, refusals, equal deadlines,
		// early wake of the later of two equal deadlines, and missed ticks that overrun deadlines.
		queue_req(ACT_TICK, 4'd0, 32'd0);
		queue_req(ACT_MISSED, 4'd0, 32'd0);
		queue_req(ACT_TICK, 4'd0, 32'd0);
		queue_req(ACT_INSERT, 4'd0, 32'd0);
		queue_req(ACT_INSERT, 4'd1, 32'hFFFF_FFFF);
		queue_req(ACT_WAKE, 4'd0, 32'd0);
		queue_req(ACT_INSERT, 4'd2, 32'd1);
		queue_req(ACT_INSERT, 4'd3, 32'd1);
		queue_req(ACT_INSERT, 4'd4, 32'd3);
		queue_req(ACT_INSERT, 4'd2, 32'd5);
		queue_req(ACT_INSERT, 4'd15, 32'd2);
		queue_req(ACT_INSERT, 4'd5, 32'hFFFF_FFFE);
		queue_req(ACT_WAKE, 4'd3, 32'd0);
		queue_req(ACT_WAKE, 4'd3, 32'hFFFF_FFFF);
		queue_req(ACT_INSERT, 4'd3, 32'd1);
		queue_req(ACT_TICK, 4'd0, 32'd0);
		queue_req(ACT_MISSED, 4'd15, 32'd0);
		queue_req(ACT_MISSED, 4'd0, 32'd0);
		queue_req(ACT_TICK, 4'd0, 32'd0);
		queue_req(ACT_INSERT, 4'd6, 32'd2);
		queue_req(ACT_MISSED, 4'd0, 32'd0);
		queue_req(ACT_MISSED, 4'd0, 32'd0);
		queue_req(ACT_MISSED, 4'd0, 32'd0);
		queue_req(ACT_TICK, 4'd0, 32'd0);
		queue_req(ACT_WAKE, 4'd5, 32'd0);
		queue_random_reqs(95);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait_quiet();
		@(posedge clk);
		send_idle_pct = 76;
		recv_idle_pct = 37;
		queue_random_reqs(95);

		wait_quiet();
		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_reqs(95);

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fault_count == 0 && pending_replies.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
